[sv/psh_pkg.sv]
// Shared constants and types for the polynomial substring hash block.
// Used by psh_modmul and polynomial_substring_hash; depends on nothing else.

`default_nettype none

package psh_pkg;

    localparam int unsigned STORE_DEPTH_DEFAULT = 4096;

    localparam int unsigned HASH_W  = 30;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 12;

    typedef logic [HASH_W-1:0] hash_t;

    // Modulus, base, and the inverse of the base (base raised to modulus minus two).
    localparam hash_t HASH_MOD  = 30'd1000000007;
    localparam hash_t HASH_BASE = 30'd1000003;
    localparam hash_t BASE_INV  = 30'd486802543;

    // Barrett factor floor(2^60 / modulus) for products below 2^60.
    localparam logic [30:0] BARRETT_MU =
        31'(64'd1152921504606846976 / 64'd1000000007);

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

endpackage

`default_nettype wire

[sv/polynomial_substring_hash.sv]
// Append: the input stalls while three products go through the six-stage modular
// multiplier and the stores are written; an append to a full string is dropped at once.
// Query: the stores are read and one product is issued; the deliver state, which waits on
// result_stall, registers the result and ends the input stall; a bad query goes straight
// to it. Reset clears length, powers and control at once; the stores are not cleared.
// Holds the controller and both stores; depends on psh_pkg and psh_modmul.

`default_nettype none

module polynomial_substring_hash #(
    parameter int unsigned STORE_DEPTH = psh_pkg::STORE_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic                            command,
    input  wire logic [psh_pkg::BYTE_W-1:0]      byte_value,
    input  wire logic                            restart,
    input  wire logic [psh_pkg::INDEX_W-1:0]     left_index,
    input  wire logic [psh_pkg::INDEX_W-1:0]     right_index,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output psh_pkg::hash_t                       hash_value,
    output logic                                 query_error
);

    localparam int unsigned LEN_W  = $clog2(STORE_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned CMP_W  = (LEN_W > psh_pkg::INDEX_W) ? LEN_W : psh_pkg::INDEX_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_A_TERM  = 4'd1;
    localparam logic [3:0] ST_A_POW   = 4'd2;
    localparam logic [3:0] ST_A_INV   = 4'd3;
    localparam logic [3:0] ST_A_WAIT  = 4'd4;
    localparam logic [3:0] ST_A_SUM   = 4'd5;
    localparam logic [3:0] ST_Q_RD1   = 4'd6;
    localparam logic [3:0] ST_Q_RD2   = 4'd7;
    localparam logic [3:0] ST_Q_DIFF  = 4'd8;
    localparam logic [3:0] ST_Q_WAIT  = 4'd9;
    localparam logic [3:0] ST_DELIVER = 4'd10;

    // Control state.
    logic [3:0]                   state_reg, state_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    psh_pkg::hash_t               pow_reg, pow_next;
    psh_pkg::hash_t               inv_reg, inv_next;
    psh_pkg::hash_t               prefix_reg, prefix_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         result_valid_reg, result_valid_next;

    // Payload.
    logic [psh_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic [psh_pkg::INDEX_W-1:0]  left_reg, left_next;
    logic [psh_pkg::INDEX_W-1:0]  right_reg, right_next;
    psh_pkg::hash_t               term_reg, term_next;
    psh_pkg::hash_t               hi_reg, hi_next;
    psh_pkg::hash_t               invl_reg, invl_next;
    psh_pkg::hash_t               res_hash_reg, res_hash_next;
    logic                         res_err_reg, res_err_next;
    psh_pkg::hash_t               hash_out_reg, hash_out_next;
    logic                         err_out_reg, err_out_next;

    // Stores.
    psh_pkg::hash_t               prefix_mem [0:STORE_DEPTH-1];
    psh_pkg::hash_t               inv_mem [0:STORE_DEPTH-1];
    psh_pkg::hash_t               prefix_rd;
    psh_pkg::hash_t               inv_rd;
    logic                         prefix_we;
    logic                         inv_we;
    logic [ADDR_W-1:0]            prefix_raddr;
    logic [ADDR_W-1:0]            inv_raddr;
    logic [ADDR_W-1:0]            waddr;

    // Multiplier.
    logic                         mul_valid;
    psh_pkg::hash_t               mul_a;
    psh_pkg::hash_t               mul_b;
    logic                         mul_res_valid;
    psh_pkg::hash_t               mul_res;

    // Datapath helpers.
    logic [LEN_W-1:0]             len_eff;
    logic                         bad_query;
    logic [30:0]                  sum_wide;
    psh_pkg::hash_t               sum_mod;
    psh_pkg::hash_t               lo_value;
    logic [30:0]                  diff_wide;
    psh_pkg::hash_t               diff_value;

    psh_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (mul_valid),
        .op_a      (mul_a),
        .op_b      (mul_b),
        .res_valid (mul_res_valid),
        .res_value (mul_res)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign hash_value   = hash_out_reg;
    assign query_error  = err_out_reg;

    assign len_eff   = restart ? '0 : len_reg;
    assign bad_query = (CMP_W'(right_index) >= CMP_W'(len_reg)) || (left_index > right_index);
    assign waddr     = len_reg[ADDR_W-1:0];

    assign sum_wide = {1'b0, prefix_reg} + {1'b0, term_reg};
    assign sum_mod  = (sum_wide >= 31'(psh_pkg::HASH_MOD))
                      ? 30'(sum_wide - 31'(psh_pkg::HASH_MOD)) : sum_wide[29:0];

    // Position zero has no earlier prefix; it counts as zero.
    assign lo_value   = (left_reg == '0) ? '0 : prefix_rd;
    assign diff_wide  = (hi_reg >= lo_value)
                        ? 31'(hi_reg - lo_value)
                        : ({1'b0, hi_reg} + 31'(psh_pkg::HASH_MOD) - {1'b0, lo_value});
    assign diff_value = diff_wide[29:0];

    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        pow_next          = pow_reg;
        inv_next          = inv_reg;
        prefix_next       = prefix_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg & result_stall;
        byte_next         = byte_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        term_next         = term_reg;
        hi_next           = hi_reg;
        invl_next         = invl_reg;
        res_hash_next     = res_hash_reg;
        res_err_next      = res_err_reg;
        hash_out_next     = hash_out_reg;
        err_out_next      = err_out_reg;
        mul_valid         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        prefix_we         = 1'b0;
        inv_we            = 1'b0;
        prefix_raddr      = ADDR_W'(right_reg);
        inv_raddr         = ADDR_W'(left_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    byte_next  = byte_value;
                    left_next  = left_index;
                    right_next = right_index;
                    if (command == psh_pkg::CMD_QUERY)
                    begin
                        if (bad_query)
                        begin
                            res_hash_next = '0;
                            res_err_next  = 1'b1;
                            state_next    = ST_DELIVER;
                        end
                        else
                        begin
                            state_next = ST_Q_RD1;
                        end
                    end
                    else
                    begin
                        if (restart)
                        begin
                            len_next    = '0;
                            pow_next    = psh_pkg::hash_t'(1);
                            inv_next    = psh_pkg::hash_t'(1);
                            prefix_next = '0;
                        end
                        // A full string ignores the character.
                        if (len_eff == LEN_W'(STORE_DEPTH))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_A_TERM;
                        end
                    end
                end
            end
            ST_A_TERM:
            begin
                mul_valid  = 1'b1;
                mul_a      = psh_pkg::hash_t'(byte_reg);
                mul_b      = pow_reg;
                inv_we     = 1'b1;
                state_next = ST_A_POW;
            end
            ST_A_POW:
            begin
                mul_valid  = 1'b1;
                mul_a      = pow_reg;
                mul_b      = psh_pkg::HASH_BASE;
                state_next = ST_A_INV;
            end
            ST_A_INV:
            begin
                mul_valid  = 1'b1;
                mul_a      = inv_reg;
                mul_b      = psh_pkg::BASE_INV;
                cnt_next   = '0;
                state_next = ST_A_WAIT;
            end
            ST_A_WAIT:
            begin
                // Products come back in issue order: term, power, inverse.
                if (mul_res_valid)
                begin
                    cnt_next = cnt_reg + 2'd1;
                    unique case (cnt_reg)
                        2'd0:    term_next = mul_res;
                        2'd1:    pow_next  = mul_res;
                        default:
                        begin
                            inv_next   = mul_res;
                            state_next = ST_A_SUM;
                        end
                    endcase
                end
            end
            ST_A_SUM:
            begin
                prefix_next = sum_mod;
                prefix_we   = 1'b1;
                len_next    = len_reg + LEN_W'(1);
                state_next  = ST_IDLE;
            end
            ST_Q_RD1:
            begin
                state_next = ST_Q_RD2;
            end
            ST_Q_RD2:
            begin
                hi_next      = prefix_rd;
                invl_next    = inv_rd;
                prefix_raddr = ADDR_W'(left_reg - psh_pkg::INDEX_W'(1));
                state_next   = ST_Q_DIFF;
            end
            ST_Q_DIFF:
            begin
                mul_valid  = 1'b1;
                mul_a      = diff_value;
                mul_b      = invl_reg;
                state_next = ST_Q_WAIT;
            end
            ST_Q_WAIT:
            begin
                if (mul_res_valid)
                begin
                    res_hash_next = mul_res;
                    res_err_next  = 1'b0;
                    state_next    = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    hash_out_next     = res_hash_reg;
                    err_out_next      = res_err_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            len_reg          <= '0;
            pow_reg          <= psh_pkg::hash_t'(1);
            inv_reg          <= psh_pkg::hash_t'(1);
            prefix_reg       <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            pow_reg          <= pow_next;
            inv_reg          <= inv_next;
            prefix_reg       <= prefix_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        term_reg     <= term_next;
        hi_reg       <= hi_next;
        invl_reg     <= invl_next;
        res_hash_reg <= res_hash_next;
        res_err_reg  <= res_err_next;
        hash_out_reg <= hash_out_next;
        err_out_reg  <= err_out_next;
    end

    // Writes finish before the block returns to idle, so a later query never
    // reads an entry in the same cycle it is written.
    always_ff @(posedge clk)
    begin
        if (prefix_we)
        begin
            prefix_mem[waddr] <= prefix_next;
        end
        prefix_rd <= prefix_mem[prefix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[waddr] <= inv_reg;
        end
        inv_rd <= inv_mem[inv_raddr];
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(STORE_DEPTH))
        else $error("stored length beyond capacity");

    a_result_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DELIVER))
        else $error("result appeared outside the deliver state");

    a_error_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && err_out_reg) |-> (hash_out_reg == '0))
        else $error("error result carries a nonzero hash");

    a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_res_valid |-> (state_reg == ST_A_WAIT || state_reg == ST_Q_WAIT))
        else $error("multiplier result arrived while not waiting for one");

    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        mul_res_valid |-> (mul_res < psh_pkg::HASH_MOD))
        else $error("multiplier result not fully reduced");

endmodule

`default_nettype wire

[sv/psh_modmul.sv]
// Pipelined modular multiplier: (a * b) mod 1000000007 with Barrett reduction.
// Six register stages, one new operation per cycle; depends on psh_pkg.

`default_nettype none

module psh_modmul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    input  wire psh_pkg::hash_t op_a,
    input  wire psh_pkg::hash_t op_b,
    output logic               res_valid,
    output psh_pkg::hash_t     res_value
);

    logic [5:0]           valid_reg;
    logic [59:0]          prod_reg;
    logic [61:0]          q2_reg;
    logic [31:0]          xlo1_reg;
    logic [31:0]          xlo2_reg;
    logic [31:0]          qm_reg;
    logic [31:0]          r_reg;
    logic [30:0]          c1_reg;
    psh_pkg::hash_t       c2_reg;

    logic [59:0]          prod_full;
    logic [61:0]          q2_full;
    logic [60:0]          qm_full;
    logic [31:0]          r_value;
    logic [30:0]          c1_value;
    psh_pkg::hash_t       c2_value;

    assign prod_full = 60'(op_a) * 60'(op_b);
    assign q2_full   = 62'(prod_reg[59:29]) * 62'(psh_pkg::BARRETT_MU);
    assign qm_full   = 61'(q2_reg[61:31]) * 61'(psh_pkg::HASH_MOD);

    // The quotient estimate is short by at most two, so the remainder stays
    // below three times the modulus and fits in 32 bits.
    assign r_value  = xlo2_reg - qm_reg;
    assign c1_value = (r_reg >= 32'(psh_pkg::HASH_MOD))
                      ? 31'(r_reg - 32'(psh_pkg::HASH_MOD)) : r_reg[30:0];
    assign c2_value = (c1_reg >= 31'(psh_pkg::HASH_MOD))
                      ? 30'(c1_reg - 31'(psh_pkg::HASH_MOD)) : c1_reg[29:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], op_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        q2_reg   <= q2_full;
        xlo1_reg <= prod_reg[31:0];
        qm_reg   <= qm_full[31:0];
        xlo2_reg <= xlo1_reg;
        r_reg    <= r_value;
        c1_reg   <= c1_value;
        c2_reg   <= c2_value;
    end

    assign res_valid = valid_reg[5];
    assign res_value = c2_reg;

endmodule

`default_nettype wire
